### hdl/assert_macros.svh
// Assertion macros for the tilt angle pipeline.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NORST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

### hdl/tilt_pkg.sv
package tilt_pkg;
   localparam int SampleBitsDef = 8;
   localparam int FracBitsDef   = 8;
   localparam int AngleBits     = 16;
   localparam int CordicIters   = 20;
   localparam int AngFrac       = 16;
   // root and sample terms carry 16 fraction bits
   localparam int TermFrac      = 16;
   localparam int RootSteps     = 1;

   localparam logic [22:0] Deg90 = 23'(90 << AngFrac);

   typedef enum logic [1:0] {
      CASE_CORDIC = 2'b00,
      CASE_ZERO   = 2'b01,
      CASE_RIGHT  = 2'b10,
      CASE_UNDEF  = 2'b11
   } case_type;

   function automatic logic [22:0] atan_deg(input logic [4:0] i);
      logic [22:0] v;
      case (i)
         5'd0:  v = 23'd2949120;
         5'd1:  v = 23'd1740967;
         5'd2:  v = 23'd919879;
         5'd3:  v = 23'd466945;
         5'd4:  v = 23'd234379;
         5'd5:  v = 23'd117304;
         5'd6:  v = 23'd58666;
         5'd7:  v = 23'd29335;
         5'd8:  v = 23'd14668;
         5'd9:  v = 23'd7334;
         5'd10: v = 23'd3667;
         5'd11: v = 23'd1833;
         5'd12: v = 23'd917;
         5'd13: v = 23'd458;
         5'd14: v = 23'd229;
         5'd15: v = 23'd115;
         5'd16: v = 23'd57;
         5'd17: v = 23'd29;
         5'd18: v = 23'd14;
         5'd19: v = 23'd7;
         default: v = '0;
      endcase
      return v;
   endfunction
endpackage

### hdl/accel_tilt_angles.sv
// Tilt angle pipeline for a three-axis accelerometer.
// Input word on req_: accel_x, accel_y, accel_z (signed samples).
// Result word on rsp_: x_tilt, y_tilt, z_tilt (signed degrees with
// FRAC_BITS fraction bits) and a three-bit undefined flag set for a
// zero-over-zero ratio.
// Throughput: one word per cycle while the output is not stalled. Stages:
// one register for squares, one per root bit, one per CORDIC iteration and
// one for clamping; the result is then held in the output register.
// The whole pipeline advances as one; when rsp_tready is low and the
// output word is still held, every stage holds and req_tready drops, so
// nothing is lost or repeated.
// Reset (synchronous, active high) clears all valid bits; the data
// registers are not reset.
`include "assert_macros.svh"
module accel_tilt_angles #(
   parameter int SAMPLE_BITS = tilt_pkg::SampleBitsDef,
   parameter int FRAC_BITS   = tilt_pkg::FracBitsDef,
   localparam int InBytes    = (3 * SAMPLE_BITS + 7) / 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // accel_x, accel_y, accel_z
   input  logic [8*InBytes-1:0] req_tdata,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // x_tilt, y_tilt, z_tilt, undefined_flag, zero pad
   output logic [55:0]          rsp_tdata
);
   localparam int SB    = SAMPLE_BITS;
   localparam int TermB = SB + 16;
   localparam int Groups = (TermB + tilt_pkg::RootSteps - 1) / tilt_pkg::RootSteps;
   localparam int Lat   = 1 + Groups + tilt_pkg::CordicIters + 1;

   logic advance;
   logic [Lat-1:0] vld_ff;
   logic rsp_valid_ff;
   logic [55:0] rsp_data_ff;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         vld_ff       <= {vld_ff[Lat-2:0], req_tvalid};
         rsp_valid_ff <= vld_ff[Lat-1];
      end
   end

   // square stage
   logic signed [SB-1:0] ax, ay, az;
   assign ax = req_tdata[SB-1:0];
   assign ay = req_tdata[2*SB-1:SB];
   assign az = req_tdata[3*SB-1:2*SB];

   logic [SB-1:0]   mx_ff, my_ff, mz_ff;
   logic [2*SB-1:0] sx_ff, sy_ff, sz_ff;
   logic [2:0]      sg_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         mx_ff <= ax[SB-1] ? SB'(-ax) : SB'(ax);
         my_ff <= ay[SB-1] ? SB'(-ay) : SB'(ay);
         mz_ff <= az[SB-1] ? SB'(-az) : SB'(az);
         sx_ff <= (2*SB)'(ax * ax);
         sy_ff <= (2*SB)'(ay * ay);
         sz_ff <= (2*SB)'(az * az);
         sg_ff <= {az[SB-1], ay[SB-1], ax[SB-1]};
      end
   end

   // sums of squares never exceed 2^(2*SB-1)
   logic [TermB-1:0] rx, ry, rz;
   tilt_sqrt #(.SampleBits(SB)) u_sqrt_x (.clock, .advance,
      .sum_sq((2*SB)'(sy_ff + sz_ff)), .root(rx));
   tilt_sqrt #(.SampleBits(SB)) u_sqrt_y (.clock, .advance,
      .sum_sq((2*SB)'(sx_ff + sz_ff)), .root(ry));
   tilt_sqrt #(.SampleBits(SB)) u_sqrt_z (.clock, .advance,
      .sum_sq((2*SB)'(sx_ff + sy_ff)), .root(rz));

   // delay magnitudes and signs alongside the root pipeline
   logic [SB-1:0] mxd_ff [Groups], myd_ff [Groups], mzd_ff [Groups];
   logic [2:0]    sgd_ff [Groups];
   always_ff @(posedge clock) begin
      if (advance) begin
         mxd_ff[0] <= mx_ff;
         myd_ff[0] <= my_ff;
         mzd_ff[0] <= mz_ff;
         sgd_ff[0] <= sg_ff;
         for (int k = 1; k < Groups; k++) begin
            mxd_ff[k] <= mxd_ff[k-1];
            myd_ff[k] <= myd_ff[k-1];
            mzd_ff[k] <= mzd_ff[k-1];
            sgd_ff[k] <= sgd_ff[k-1];
         end
      end
   end

   logic [15:0] tx, ty, tz;
   logic        ux, uy, uz;
   tilt_cordic #(.SampleBits(SB), .FracBits(FRAC_BITS)) u_cordic_x (.clock, .advance,
      .num({mxd_ff[Groups-1], 16'd0}), .den(rx), .neg(sgd_ff[Groups-1][0]),
      .angle(tx), .undef(ux));
   tilt_cordic #(.SampleBits(SB), .FracBits(FRAC_BITS)) u_cordic_y (.clock, .advance,
      .num({myd_ff[Groups-1], 16'd0}), .den(ry), .neg(sgd_ff[Groups-1][1]),
      .angle(ty), .undef(uy));
   tilt_cordic #(.SampleBits(SB), .FracBits(FRAC_BITS)) u_cordic_z (.clock, .advance,
      .num(rz), .den({mzd_ff[Groups-1], 16'd0}), .neg(sgd_ff[Groups-1][2]),
      .angle(tz), .undef(uz));

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= {5'd0, uz, uy, ux, tz, ty, tx};
      end
   end

   `ASSERT_CLK(a_hold_out, clock, reset,
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata),
      "output word changed while stalled")
   `ASSERT_CLK(a_ready_stall, clock, reset,
      !req_tready |-> rsp_tvalid && !rsp_tready, "input stalled without output stall")
   `ASSERT_CLK(a_pipe_flow, clock, reset,
      advance |=> rsp_tvalid == $past(vld_ff[Lat-1]), "valid bit lost in pipeline")
   `ASSERT_NORST(a_reset_clear, clock,
      reset |=> !rsp_tvalid && vld_ff == '0, "reset left valid bits set")
endmodule

### hdl/tilt_sqrt.sv
// Pipelined integer square root of (s << 32), one result bit per stage.
// The root has SampleBits+16 bits; stages are grouped RootSteps bits each.
module tilt_sqrt #(
   parameter int SampleBits = tilt_pkg::SampleBitsDef,
   localparam int SumBits  = 2 * SampleBits,
   localparam int RootBits = SampleBits + 16
) (
   input  logic                clock,
   input  logic                advance,
   input  logic [SumBits-1:0]  sum_sq,
   output logic [RootBits-1:0] root
);
   localparam int RadBits = 2 * RootBits;
   localparam int Groups  = (RootBits + tilt_pkg::RootSteps - 1) / tilt_pkg::RootSteps;

   logic [RadBits-1:0]  rad_ff  [Groups];
   logic [RootBits-1:0] res_ff  [Groups];
   logic [RadBits+1:0]  rem_ff  [Groups];

   for (genvar g = 0; g < Groups; g++) begin : g_grp
      logic [RadBits-1:0]  rad_st, rad_in;
      logic [RootBits-1:0] res_st, res_in;
      logic [RadBits+1:0]  rem_st, rem_in;
      if (g == 0) begin : g_first
         assign rad_st = {sum_sq, 32'd0};
         assign res_st = '0;
         assign rem_st = '0;
      end else begin : g_next
         assign rad_st = rad_ff[g-1];
         assign res_st = res_ff[g-1];
         assign rem_st = rem_ff[g-1];
      end
      always_comb begin
         logic [RadBits+1:0] trial;
         rad_in = rad_st;
         res_in = res_st;
         rem_in = rem_st;
         for (int k = 0; k < tilt_pkg::RootSteps; k++) begin
            if (g * tilt_pkg::RootSteps + k < RootBits) begin
               rem_in = {rem_in[RadBits-1:0], rad_in[RadBits-1 -: 2]};
               rad_in = {rad_in[RadBits-3:0], 2'b00};
               trial  = (RadBits+2)'({res_in, 2'b01});
               if (rem_in >= trial) begin
                  rem_in = rem_in - trial;
                  res_in = {res_in[RootBits-2:0], 1'b1};
               end else begin
                  res_in = {res_in[RootBits-2:0], 1'b0};
               end
            end
         end
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            rad_ff[g] <= rad_in;
            res_ff[g] <= res_in;
            rem_ff[g] <= rem_in;
         end
      end
   end

   assign root = res_ff[Groups-1];
endmodule

### hdl/tilt_cordic.sv
// Pipelined CORDIC vectoring unit: angle of (den, num) plus rounding and sign.
module tilt_cordic #(
   parameter int SampleBits = tilt_pkg::SampleBitsDef,
   parameter int FracBits   = tilt_pkg::FracBitsDef,
   localparam int TermBits  = SampleBits + 16
) (
   input  logic                           clock,
   input  logic                           advance,
   input  logic [TermBits-1:0]            num,
   input  logic [TermBits-1:0]            den,
   input  logic                           neg,
   output logic [tilt_pkg::AngleBits-1:0] angle,
   output logic                           undef
);
   localparam int N  = tilt_pkg::CordicIters;
   localparam int VB = TermBits + 3;
   localparam int Sh = tilt_pkg::AngFrac - FracBits;

   logic signed [VB-1:0] x_ff [1:N];
   logic signed [VB-1:0] y_ff [1:N];
   logic signed [23:0]   z_ff [1:N];
   tilt_pkg::case_type   c_ff [1:N];
   logic                 n_ff [1:N];
   tilt_pkg::case_type   case_st;

   always_comb begin
      if (num == '0 && den == '0) case_st = tilt_pkg::CASE_UNDEF;
      else if (den == '0)         case_st = tilt_pkg::CASE_RIGHT;
      else if (num == '0)         case_st = tilt_pkg::CASE_ZERO;
      else                        case_st = tilt_pkg::CASE_CORDIC;
   end

   for (genvar i = 0; i < N; i++) begin : g_it
      logic signed [VB-1:0] x_st, y_st;
      logic signed [23:0]   z_st;
      tilt_pkg::case_type   c_st;
      logic                 n_st;
      if (i == 0) begin : g_first
         assign x_st = VB'(den);
         assign y_st = VB'(num);
         assign z_st = '0;
         assign c_st = case_st;
         assign n_st = neg;
      end else begin : g_next
         assign x_st = x_ff[i];
         assign y_st = y_ff[i];
         assign z_st = z_ff[i];
         assign c_st = c_ff[i];
         assign n_st = n_ff[i];
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            if (!y_st[VB-1]) begin
               x_ff[i+1] <= x_st + (y_st >>> i);
               y_ff[i+1] <= y_st - (x_st >>> i);
               z_ff[i+1] <= z_st + $signed({1'b0, tilt_pkg::atan_deg(5'(i))});
            end else begin
               x_ff[i+1] <= x_st - (y_st >>> i);
               y_ff[i+1] <= y_st + (x_st >>> i);
               z_ff[i+1] <= z_st - $signed({1'b0, tilt_pkg::atan_deg(5'(i))});
            end
            c_ff[i+1] <= c_st;
            n_ff[i+1] <= n_st;
         end
      end
   end

   logic signed [23:0] mag_in, mag_ff;
   logic               neg_ff, undef_ff;
   always_comb begin
      case (c_ff[N])
         tilt_pkg::CASE_CORDIC: begin
            if (z_ff[N] < 0)                          mag_in = '0;
            else if (z_ff[N] > $signed({1'b0, tilt_pkg::Deg90})) mag_in = {1'b0, tilt_pkg::Deg90};
            else                                      mag_in = z_ff[N];
         end
         tilt_pkg::CASE_RIGHT: mag_in = {1'b0, tilt_pkg::Deg90};
         default:              mag_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mag_ff   <= mag_in;
         neg_ff   <= n_ff[N];
         undef_ff <= (c_ff[N] == tilt_pkg::CASE_UNDEF);
      end
   end

   logic signed [24:0] rnd;
   logic signed [24:0] sgn;
   always_comb begin
      rnd = ({mag_ff[23], mag_ff} + 25'(1 << (Sh - 1))) >>> Sh;
      sgn = (neg_ff && !undef_ff) ? -rnd : rnd;
      if (sgn > 25'sd32767)       angle = 16'h7fff;
      else if (sgn < -25'sd32768) angle = 16'h8000;
      else                        angle = sgn[15:0];
   end
   assign undef = undef_ff;
endmodule
